/* rtl/core/cmnc_pkg.sv */
// Shared types, codes and helpers of the CANopen master node configurator.
`default_nettype none
package cmnc_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [10:0] rx_id;
        logic [63:0] rx_bytes;
        logic [31:0] now_ms;
        logic [2:0]  load_node;
        logic [3:0]  load_slot;
        logic [2:0]  load_size;
        logic [15:0] load_index;
        logic [7:0]  load_subindex;
        logic [31:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic [10:0] tx_id;
        logic [3:0]  tx_len;
        logic [63:0] tx_bytes;
        logic        last;
    } out_item_t;

    localparam logic [1:0] CMD_FRAME  = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;
    localparam logic [1:0] CMD_RESET  = 2'd3;

    localparam logic [1:0] CFG_NODE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_NODE_IDS     = 2'd1;
    localparam logic [1:0] CFG_ENTRY_COUNTS = 2'd2;
    localparam logic [1:0] CFG_SDO_TIMEOUT  = 2'd3;

    localparam logic [1:0] PH_RESET_COM = 2'd0;
    localparam logic [1:0] PH_PRE_OP    = 2'd1;
    localparam logic [1:0] PH_OP        = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    localparam logic [3:0] FN_SDO_RES = 4'hB;
    localparam logic [3:0] FN_BOOTUP  = 4'hE;

    localparam logic [7:0] SDO_RES_OK    = 8'h60;
    localparam logic [7:0] SDO_RES_ABORT = 8'h80;
    localparam logic [7:0] NMT_START     = 8'h01;
    localparam logic [7:0] NMT_RESET_ALL = 8'h81;

    localparam logic [10:0] ID_NMT  = 11'h000;
    localparam logic [10:0] ID_SYNC = 11'h080;
    localparam logic [10:0] ID_SDO  = 11'h600;

    localparam int          PACKED_SLOTS  = 6;
    localparam logic [15:0] TIMEOUT_RESET = 16'd20;

    function automatic logic [7:0] sdo_cmd(input logic [1:0] size_m1);
        logic [7:0] c;
        case (size_m1)
            2'd0:    c = 8'h2f;
            2'd1:    c = 8'h2b;
            2'd2:    c = 8'h27;
            default: c = 8'h23;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] slot_id(input logic [41:0] ids, input logic [4:0] idx);
        logic [6:0] r;
        r = 7'd0;
        for (int k = 0; k < PACKED_SLOTS; k++) begin
            if (idx == 5'(k)) begin
                r = ids[7*k +: 7];
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] slot_cnt(input logic [29:0] cnts, input logic [4:0] idx);
        logic [4:0] r;
        r = 5'd0;
        for (int k = 0; k < PACKED_SLOTS; k++) begin
            if (idx == 5'(k)) begin
                r = cnts[5*k +: 5];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/cmnc_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module cmnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/canopen_master_node_configurator.sv */
// Top level of the CANopen master node configurator: command sequencer over node and entry RAMs.
// Frames and entry loads are handled as the item is taken; a reset-all frame leaves via S_FLUSH.
// An update scans each node's phase (S_SCAN, S_SCAN_CHK), then reads and processes each node
// (S_NODE_RD, S_NODE_EV, S_NODE_SDO, S_EMIT); the node RAM read sets the per-node pace.
// The next item is taken once the last frame of an update is in the output register.
// Reset: all nodes in reset communication (node RAM valid bits cleared), SDO status ok,
// SDO timeout 20 ms; the entry table is undefined until loaded. No clearing pass.
`default_nettype none
module canopen_master_node_configurator #(
    parameter int MAX_NODES   = 6,
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cmnc_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cmnc_pkg::out_item_t     out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [41:0]        cfg_data
);
    import cmnc_pkg::*;

    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int NAW = MAX_NODES > 1 ? $clog2(MAX_NODES) : 1;
    localparam int ED  = MAX_NODES * MAX_ENTRIES;
    localparam int EAW = ED > 1 ? $clog2(ED) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SCAN_CHK, S_NODE_RD, S_NODE_EV, S_NODE_SDO, S_EMIT, S_FLUSH
    } state_t;

    state_t         state_reg;
    logic [2:0]     node_count_reg;
    logic [41:0]    node_ids_reg;
    logic [29:0]    entry_counts_reg;
    logic [15:0]    sdo_timeout_reg;
    logic [1:0]     sdo_status_reg;
    logic [31:0]    sdo_sent_reg;
    logic [31:0]    now_reg;
    logic [NW-1:0]  i_reg;
    logic           all_op_reg;
    logic [4:0]     pos_s_reg;
    logic           node_valid_reg [MAX_NODES];
    out_item_t      new_reg;
    out_item_t      held_reg;
    logic           held_v_reg;
    out_item_t      out_reg;
    logic           out_v_reg;

    logic [NW-1:0]  used;
    logic           in_acc;
    logic           out_free;
    logic           out_load;
    logic [3:0]     rx_fn;
    logic           found;
    logic [NAW-1:0] match_idx;
    logic [7:0]     node_rd;
    logic [57:0]    ent_rd;
    logic           nvalid;
    logic [1:0]     phase_rd;
    logic           fp_rd;
    logic [4:0]     pos_rd;
    logic [4:0]     cnt_raw;
    logic [4:0]     cnt_i;
    logic [6:0]     id_i;
    logic           busy;
    logic           expired;
    logic           pos_lt;
    logic [4:0]     pos_new;
    logic           skip;
    logic           do_sdo;
    logic           do_start;
    logic           n_we;
    logic [NAW-1:0] n_waddr;
    logic [7:0]     n_wdata;
    logic           e_we;
    logic [EAW-1:0] e_waddr;
    logic [57:0]    e_wdata;
    logic [EAW-1:0] e_raddr;
    logic [2:0]     ld_size;
    logic [1:0]     e_szm1;
    logic [31:0]    e_val;
    out_item_t      sdo_frame;
    out_item_t      start_frame;

    assign used     = (32'(node_count_reg) > MAX_NODES) ? NW'(MAX_NODES) : NW'(node_count_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_v_reg || out_ready;
    assign out_load  = ((state_reg == S_EMIT) || (state_reg == S_FLUSH)) && held_v_reg
                       && out_free;
    assign rx_fn     = in_data.rx_id[10:7];

    always_comb
    begin
        found     = 1'b0;
        match_idx = '0;
        for (int k = MAX_NODES - 1; k >= 0; k--)
        begin
            if ((k < 32'(used)) && (slot_id(node_ids_reg, 5'(k)) == in_data.rx_id[6:0]))
            begin
                found     = 1'b1;
                match_idx = NAW'(k);
            end
        end
    end

    assign nvalid   = node_valid_reg[i_reg[NAW-1:0]];
    assign phase_rd = nvalid ? node_rd[7:6] : PH_RESET_COM;
    assign fp_rd    = nvalid ? node_rd[5] : 1'b0;
    assign pos_rd   = nvalid ? node_rd[4:0] : 5'd0;
    assign cnt_raw  = slot_cnt(entry_counts_reg, 5'(i_reg));
    assign cnt_i    = (32'(cnt_raw) > MAX_ENTRIES) ? 5'(MAX_ENTRIES) : cnt_raw;
    assign id_i     = slot_id(node_ids_reg, 5'(i_reg));
    assign busy     = (sdo_status_reg == ST_BUSY);
    assign expired  = (now_reg - sdo_sent_reg) >= {16'd0, sdo_timeout_reg};
    assign pos_lt   = pos_rd < cnt_i;
    assign pos_new  = (pos_lt && !busy && !fp_rd) ? pos_rd + 5'd1 : pos_rd;
    assign skip     = (phase_rd != PH_PRE_OP) || (pos_lt && busy && !expired);
    assign do_sdo   = !skip && pos_lt && (pos_new < cnt_i);
    assign do_start = !skip && !do_sdo;

    assign ld_size = (in_data.load_size == 3'd0) ? 3'd1 :
                     (in_data.load_size > 3'd4) ? 3'd4 : in_data.load_size;

    always_comb
    begin
        n_we    = 1'b0;
        n_waddr = i_reg[NAW-1:0];
        n_wdata = {PH_PRE_OP, 1'b0, pos_s_reg};
        if (state_reg == S_IDLE)
        begin
            n_we    = in_acc && (in_data.command == CMD_FRAME) && found && (rx_fn == FN_BOOTUP);
            n_waddr = match_idx;
            n_wdata = {PH_PRE_OP, 1'b1, 5'd0};
        end
        else if (state_reg == S_NODE_EV)
        begin
            n_we    = do_start;
            n_wdata = {PH_OP, 1'b0, pos_new};
        end
        else if (state_reg == S_NODE_SDO)
        begin
            n_we = 1'b1;
        end
    end

    assign e_we    = (state_reg == S_IDLE) && in_acc && (in_data.command == CMD_LOAD)
                     && (32'(in_data.load_node) < MAX_NODES)
                     && (32'(in_data.load_slot) < MAX_ENTRIES);
    assign e_waddr = EAW'(32'(in_data.load_node) * MAX_ENTRIES + 32'(in_data.load_slot));
    assign e_wdata = {2'(ld_size - 3'd1), in_data.load_index, in_data.load_subindex,
                      in_data.load_value};
    assign e_raddr = EAW'(32'(i_reg) * MAX_ENTRIES + 32'(pos_new));

    assign e_szm1 = ent_rd[57:56];
    always_comb
    begin
        case (e_szm1)
            2'd0:    e_val = {24'd0, ent_rd[7:0]};
            2'd1:    e_val = {16'd0, ent_rd[15:0]};
            2'd2:    e_val = {8'd0, ent_rd[23:0]};
            default: e_val = ent_rd[31:0];
        endcase
    end

    assign sdo_frame.tx_id    = ID_SDO + {4'd0, id_i};
    assign sdo_frame.tx_len   = 4'd5 + {2'd0, e_szm1};
    assign sdo_frame.tx_bytes = {e_val, ent_rd[39:32], ent_rd[55:40], sdo_cmd(e_szm1)};
    assign sdo_frame.last     = 1'b0;

    assign start_frame.tx_id    = ID_NMT;
    assign start_frame.tx_len   = 4'd2;
    assign start_frame.tx_bytes = {48'd0, 1'b0, id_i, NMT_START};
    assign start_frame.last     = 1'b0;

    cmnc_ram #(.WIDTH(8), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (i_reg[NAW-1:0]),
        .rdata (node_rd)
    );

    cmnc_ram #(.WIDTH(58), .DEPTH(ED)) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (ent_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            node_count_reg   <= 3'd0;
            node_ids_reg     <= 42'd0;
            entry_counts_reg <= 30'd0;
            sdo_timeout_reg  <= TIMEOUT_RESET;
            sdo_status_reg   <= ST_OK;
            sdo_sent_reg     <= 32'd0;
            i_reg            <= '0;
            all_op_reg       <= 1'b1;
            held_v_reg       <= 1'b0;
            out_v_reg        <= 1'b0;
            for (int k = 0; k < MAX_NODES; k++)
            begin
                node_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NODE_COUNT:   node_count_reg   <= cfg_data[2:0];
                    CFG_NODE_IDS:     node_ids_reg     <= cfg_data;
                    CFG_ENTRY_COUNTS: entry_counts_reg <= cfg_data[29:0];
                    CFG_SDO_TIMEOUT:  sdo_timeout_reg  <= cfg_data[15:0];
                    default:          ;
                endcase
            end
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
            if (n_we)
            begin
                node_valid_reg[n_waddr] <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        now_reg <= in_data.now_ms;
                        case (in_data.command)
                            CMD_FRAME:
                            begin
                                if (found && (rx_fn == FN_SDO_RES))
                                begin
                                    if (in_data.rx_bytes[7:0] == SDO_RES_OK)
                                    begin
                                        sdo_status_reg <= ST_OK;
                                    end
                                    else if (in_data.rx_bytes[7:0] == SDO_RES_ABORT)
                                    begin
                                        sdo_status_reg <= ST_FAIL;
                                    end
                                end
                            end
                            CMD_UPDATE:
                            begin
                                i_reg      <= '0;
                                all_op_reg <= 1'b1;
                                state_reg  <= S_SCAN;
                            end
                            CMD_RESET:
                            begin
                                held_reg   <= '{tx_id: ID_NMT, tx_len: 4'd2,
                                                tx_bytes: {56'd0, NMT_RESET_ALL}, last: 1'b0};
                                held_v_reg <= 1'b1;
                                state_reg  <= S_FLUSH;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (i_reg == used)
                    begin
                        i_reg <= '0;
                        if (all_op_reg)
                        begin
                            new_reg   <= '{tx_id: ID_SYNC, tx_len: 4'd0, tx_bytes: 64'd0,
                                           last: 1'b0};
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_NODE_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK:
                begin
                    if (phase_rd != PH_OP)
                    begin
                        all_op_reg <= 1'b0;
                    end
                    i_reg     <= i_reg + NW'(1);
                    state_reg <= S_SCAN;
                end
                S_NODE_RD:
                begin
                    state_reg <= (i_reg == used) ? S_FLUSH : S_NODE_EV;
                end
                S_NODE_EV:
                begin
                    if (do_sdo)
                    begin
                        pos_s_reg <= pos_new;
                        state_reg <= S_NODE_SDO;
                    end
                    else if (do_start)
                    begin
                        new_reg   <= start_frame;
                        i_reg     <= i_reg + NW'(1);
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + NW'(1);
                        state_reg <= S_NODE_RD;
                    end
                end
                S_NODE_SDO:
                begin
                    sdo_sent_reg   <= now_reg;
                    sdo_status_reg <= ST_BUSY;
                    new_reg        <= sdo_frame;
                    i_reg          <= i_reg + NW'(1);
                    state_reg      <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!held_v_reg)
                    begin
                        held_reg   <= new_reg;
                        held_v_reg <= 1'b1;
                        state_reg  <= S_NODE_RD;
                    end
                    else if (out_free)
                    begin
                        out_reg    <= held_reg;
                        held_reg   <= new_reg;
                        state_reg  <= S_NODE_RD;
                    end
                end
                S_FLUSH:
                begin
                    if (!held_v_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_reg      <= '{tx_id: held_reg.tx_id, tx_len: held_reg.tx_len,
                                          tx_bytes: held_reg.tx_bytes, last: 1'b1};
                        held_v_reg   <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !held_v_reg)
        else $error("held frame left over in idle");

    a_sdo_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NODE_SDO) |=> (sdo_status_reg == ST_BUSY))
        else $error("SDO download did not mark transfer busy");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ready) |=> (out_v_reg && $stable(out_reg)))
        else $error("stalled output frame changed");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && held_v_reg && !out_free) |=> (state_reg == S_EMIT))
        else $error("frame dropped while output stalled");
endmodule
`default_nettype wire
